FILE: rtl/isaac_pkg.sv
// Shared types and constants for the ISAAC random generator.
// Holds the controller-to-datapath command codes, the status struct and the hash constants.
package isaac_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_SEED_START  = 2'd0;
   localparam logic [1:0] OP_SEED_BYTE   = 2'd1;
   localparam logic [1:0] OP_SEED_FINISH = 2'd2;
   localparam logic [1:0] OP_DRAW        = 2'd3;

   // Datapath command codes.
   localparam logic [4:0] CMD_NOP         = 5'd0;
   localparam logic [4:0] CMD_ACCEPT      = 5'd1;
   localparam logic [4:0] CMD_SEED_INIT   = 5'd2;
   localparam logic [4:0] CMD_MIX_BEGIN   = 5'd3;
   localparam logic [4:0] CMD_MIX_RD      = 5'd4;
   localparam logic [4:0] CMD_MIX_ACC     = 5'd5;
   localparam logic [4:0] CMD_MIX_ROUND   = 5'd6;
   localparam logic [4:0] CMD_MIX_WR      = 5'd7;
   localparam logic [4:0] CMD_MIX_NEXT    = 5'd8;
   localparam logic [4:0] CMD_MIX_END     = 5'd9;
   localparam logic [4:0] CMD_C_CLEAR     = 5'd10;
   localparam logic [4:0] CMD_SB_RD       = 5'd11;
   localparam logic [4:0] CMD_SB_WR       = 5'd12;
   localparam logic [4:0] CMD_RF_BEGIN    = 5'd13;
   localparam logic [4:0] CMD_RF_RD_OTHER = 5'd14;
   localparam logic [4:0] CMD_RF_A        = 5'd15;
   localparam logic [4:0] CMD_RF_X        = 5'd16;
   localparam logic [4:0] CMD_RF_Y        = 5'd17;
   localparam logic [4:0] CMD_RF_RD_B     = 5'd18;
   localparam logic [4:0] CMD_RF_B        = 5'd19;
   localparam logic [4:0] CMD_RF_END      = 5'd20;
   localparam logic [4:0] CMD_RAW_RD      = 5'd21;
   localparam logic [4:0] CMD_MOD_LIM     = 5'd22;
   localparam logic [4:0] CMD_MOD_X       = 5'd23;
   localparam logic [4:0] CMD_MOD_STEP    = 5'd24;
   localparam logic [4:0] CMD_LIM_SAVE    = 5'd25;
   localparam logic [4:0] CMD_OUT         = 5'd26;

   // Initial mixing vector loaded by seed start.
   localparam logic [31:0] INIT_VEC [8] = '{
      32'h1367df5a, 32'h95d90059, 32'hc3163e4b, 32'h0f421ad8,
      32'hd92a4a78, 32'ha51a3c49, 32'hc4efea1b, 32'h30609119};

   // Shift amount of each line of the initialization hash; odd lines shift right.
   localparam logic [4:0] HASH_SHIFT [8] = '{
      5'd11, 5'd2, 5'd8, 5'd16, 5'd10, 5'd4, 5'd8, 5'd9};

   // Shift amounts of the refill accumulator, by word index modulo four.
   localparam logic [4:0] RF_SHIFT [4] = '{5'd13, 5'd6, 5'd2, 5'd16};

   typedef struct packed {
      logic [4:0] op;
      logic [2:0] sub;
   } ctl_cmd_type;

   typedef struct packed {
      logic c_ge;
      logic n_zero;
      logic need_refill;
      logic x_lt_lim;
      logic grp_last;
      logic idx_last;
      logic mod_last;
   } dp_status_type;

endpackage

FILE: rtl/isaac_dp.sv
// Datapath of the ISAAC random generator: pool and output buffer memories,
// hash vector, accumulators, serial modulo unit and result register. Uses isaac_pkg.
module isaac_dp #(
   parameter int WORDS = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  isaac_pkg::ctl_cmd_type   cmd,
   output isaac_pkg::dp_status_type status,
   input  logic [7:0]               req_seed_byte,
   input  logic [31:0]              req_bound,
   output logic                     rsp_strobe,
   output logic [31:0]              rsp_value
);
   import isaac_pkg::*;

   localparam int AW = $clog2(WORDS);
   localparam int SH = AW + 2;

   logic [31:0]   pool_mem [WORDS];
   logic [31:0]   ob_mem [WORDS];
   logic [WORDS-1:0] vld_ff;
   logic [31:0]   pool_rd_ff, ob_rd_ff;
   logic          rd_vld_ff;
   logic [31:0]   pool_q;

   logic [31:0]   v_ff [8];
   logic [31:0]   v_in [8];
   logic [31:0]   mvec_ff [8];
   logic [31:0]   a_ff, b_ff, c_ff, x_ff, y_ff, lim_ff, n_ff;
   logic [7:0]    byte_ff;
   logic [AW-1:0] idx_ff;
   logic [AW:0]   remain_ff;
   logic [31:0]   md_rem_ff, md_dvd_ff;
   logic [4:0]    md_cnt_ff;
   logic          strobe_ff;
   logic [31:0]   value_ff;

   logic [AW-1:0] pool_ra, pool_wa, mix_addr, other_addr;
   logic          pool_we;
   logic [31:0]   pool_wd;
   logic [2:0]    j1, j2, j3;
   logic [31:0]   hash_t, hash_x;
   logic [31:0]   mixed, a_new, y_new, b_new;
   logic [32:0]   md_t, md_next;

   // A pool entry never written since seed start reads as zero.
   assign pool_q     = rd_vld_ff ? pool_rd_ff : 32'd0;
   assign mix_addr   = idx_ff + AW'(cmd.sub);
   assign other_addr = {~idx_ff[AW-1], idx_ff[AW-2:0]};

   // Pool port address and write data selection.
   always_comb begin
      pool_ra = idx_ff;
      pool_we = 1'b0;
      pool_wa = idx_ff;
      pool_wd = y_new;
      case (cmd.op)
         CMD_MIX_RD:      pool_ra = mix_addr;
         CMD_SB_RD:       pool_ra = c_ff[AW+1:2];
         CMD_RF_RD_OTHER: pool_ra = other_addr;
         CMD_RF_A:        pool_ra = idx_ff;
         CMD_RF_X:        pool_ra = pool_q[AW+1:2];
         CMD_RF_RD_B:     pool_ra = y_ff[SH+AW-1:SH];
         CMD_MIX_WR: begin
            pool_we = 1'b1;
            pool_wa = mix_addr;
            pool_wd = v_ff[cmd.sub];
         end
         CMD_SB_WR: begin
            pool_we = 1'b1;
            pool_wa = c_ff[AW+1:2];
            pool_wd = pool_q ^ ({24'd0, byte_ff} << {c_ff[1:0], 3'b000});
         end
         CMD_RF_Y: begin
            pool_we = 1'b1;
            pool_wa = idx_ff;
            pool_wd = y_new;
         end
         default: ;
      endcase
   end

   // Pool memory with registered read.
   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem[pool_wa] <= pool_wd;
      end
      pool_rd_ff <= pool_mem[pool_ra];
   end

   // Written-entry flags; seed start clears them all at once.
   always_ff @(posedge clock) begin
      if (reset || cmd.op == CMD_SEED_INIT) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[pool_ra];
         if (pool_we) begin
            vld_ff[pool_wa] <= 1'b1;
         end
      end
   end

   // Output buffer memory, written during refill and read from the top down.
   always_ff @(posedge clock) begin
      if (cmd.op == CMD_RF_B) begin
         ob_mem[idx_ff] <= b_new;
      end
      if (cmd.op == CMD_RAW_RD) begin
         ob_rd_ff <= ob_mem[AW'(remain_ff - 1'b1)];
      end
   end

   // Hash vector update: load at mix begin, add of a pool word, or one line of the initialization hash.
   always_comb begin
      j1 = cmd.sub + 3'd1;
      j2 = cmd.sub + 3'd2;
      j3 = cmd.sub + 3'd3;
      hash_t = cmd.sub[0] ? (v_ff[j1] >> HASH_SHIFT[cmd.sub])
                          : (v_ff[j1] << HASH_SHIFT[cmd.sub]);
      hash_x = v_ff[cmd.sub] ^ hash_t;
      v_in = v_ff;
      case (cmd.op)
         CMD_MIX_BEGIN: v_in = mvec_ff;
         CMD_MIX_ACC:   v_in[cmd.sub] = v_ff[cmd.sub] + pool_q;
         CMD_MIX_ROUND: begin
            v_in[cmd.sub] = hash_x;
            v_in[j3]      = v_ff[j3] + hash_x;
            v_in[j1]      = v_ff[j1] + v_ff[j2];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   // Refill arithmetic for one word.
   always_comb begin
      mixed = idx_ff[0] ? (a_ff >> RF_SHIFT[idx_ff[1:0]]) : (a_ff << RF_SHIFT[idx_ff[1:0]]);
      a_new = (a_ff ^ mixed) + pool_q;
      y_new = pool_q + a_ff + b_ff;
      b_new = pool_q + x_ff;
   end

   // One restoring step of the serial modulo unit.
   always_comb begin
      md_t    = {md_rem_ff, md_dvd_ff[31]};
      md_next = (md_t >= {1'b0, n_ff}) ? md_t - {1'b0, n_ff} : md_t;
   end

   // Generator state: seed start and reset load the same values.
   always_ff @(posedge clock) begin
      if (reset || cmd.op == CMD_SEED_INIT) begin
         mvec_ff   <= INIT_VEC;
         a_ff      <= '0;
         b_ff      <= '0;
         c_ff      <= '0;
         remain_ff <= '0;
      end else begin
         case (cmd.op)
            CMD_MIX_END: mvec_ff <= v_ff;
            CMD_C_CLEAR: c_ff <= '0;
            CMD_SB_WR:   c_ff <= c_ff + 32'd1;
            CMD_RF_BEGIN: begin
               c_ff <= c_ff + 32'd1;
               b_ff <= b_ff + c_ff + 32'd1;
            end
            CMD_RF_A:   a_ff <= a_new;
            CMD_RF_B:   b_ff <= b_new;
            CMD_RF_END: remain_ff <= (AW+1)'(WORDS);
            CMD_RAW_RD: remain_ff <= remain_ff - 1'b1;
            default: ;
         endcase
      end
   end

   // Working registers, index and modulo unit.
   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_ACCEPT: begin
            byte_ff <= req_seed_byte;
            n_ff    <= req_bound + 32'd1;
         end
         CMD_MIX_BEGIN, CMD_RF_BEGIN: idx_ff <= '0;
         CMD_MIX_NEXT: idx_ff <= idx_ff + AW'(8);
         CMD_RF_X:     x_ff <= pool_q;
         CMD_RF_Y:     y_ff <= y_new;
         CMD_RF_B:     idx_ff <= idx_ff + 1'b1;
         CMD_MOD_LIM: begin
            md_rem_ff <= '0;
            md_dvd_ff <= 32'd0 - n_ff;
            md_cnt_ff <= '0;
         end
         CMD_MOD_X: begin
            md_rem_ff <= '0;
            md_dvd_ff <= ob_rd_ff;
            md_cnt_ff <= '0;
         end
         CMD_MOD_STEP: begin
            md_rem_ff <= md_next[31:0];
            md_dvd_ff <= {md_dvd_ff[30:0], 1'b0};
            md_cnt_ff <= md_cnt_ff + 5'd1;
         end
         CMD_LIM_SAVE: lim_ff <= md_rem_ff;
         default: ;
      endcase
   end

   // Result register, shown for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (cmd.op == CMD_OUT);
      end
      if (cmd.op == CMD_OUT) begin
         value_ff <= (n_ff == 32'd0) ? ob_rd_ff : md_rem_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_value  = value_ff;

   // Status toward the controller; the operation code is decoded there.
   assign status.c_ge        = (c_ff >= 32'(WORDS));
   assign status.n_zero      = (n_ff == 32'd0);
   assign status.need_refill = (remain_ff == '0) || (remain_ff > (AW+1)'(WORDS));
   assign status.x_lt_lim    = (ob_rd_ff < lim_ff);
   assign status.grp_last    = (idx_ff == AW'(WORDS - 8));
   assign status.idx_last    = (idx_ff == AW'(WORDS - 1));
   assign status.mod_last    = (md_cnt_ff == 5'd31);

endmodule

FILE: rtl/isaac_ctl.sv
// Controller of the ISAAC random generator: sequences seeding, mix passes,
// refills and draws by issuing one datapath command per cycle. Uses isaac_pkg.
module isaac_ctl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               req_operation,
   output logic                     busy,
   input  isaac_pkg::dp_status_type status,
   output isaac_pkg::ctl_cmd_type   cmd
);
   import isaac_pkg::*;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_DISPATCH  = 5'd1;
   localparam logic [4:0] S_SINIT     = 5'd2;
   localparam logic [4:0] S_SB_CHK    = 5'd3;
   localparam logic [4:0] S_SB_RD     = 5'd4;
   localparam logic [4:0] S_SB_WR     = 5'd5;
   localparam logic [4:0] S_MX_BEGIN  = 5'd6;
   localparam logic [4:0] S_MX_RD     = 5'd7;
   localparam logic [4:0] S_MX_ACC    = 5'd8;
   localparam logic [4:0] S_MX_RND    = 5'd9;
   localparam logic [4:0] S_MX_WR     = 5'd10;
   localparam logic [4:0] S_MX_NEXT   = 5'd11;
   localparam logic [4:0] S_MX_END    = 5'd12;
   localparam logic [4:0] S_CCLR      = 5'd13;
   localparam logic [4:0] S_DR_CHK    = 5'd14;
   localparam logic [4:0] S_LIM_START = 5'd15;
   localparam logic [4:0] S_LIM_STEP  = 5'd16;
   localparam logic [4:0] S_LIM_END   = 5'd17;
   localparam logic [4:0] S_RAW_CHK   = 5'd18;
   localparam logic [4:0] S_RF_BEGIN  = 5'd19;
   localparam logic [4:0] S_RF_OTHER  = 5'd20;
   localparam logic [4:0] S_RF_A      = 5'd21;
   localparam logic [4:0] S_RF_X      = 5'd22;
   localparam logic [4:0] S_RF_Y      = 5'd23;
   localparam logic [4:0] S_RF_RD_B   = 5'd24;
   localparam logic [4:0] S_RF_B      = 5'd25;
   localparam logic [4:0] S_RF_END    = 5'd26;
   localparam logic [4:0] S_RAW_RD    = 5'd27;
   localparam logic [4:0] S_RAW_EVAL  = 5'd28;
   localparam logic [4:0] S_X_START   = 5'd29;
   localparam logic [4:0] S_X_STEP    = 5'd30;
   localparam logic [4:0] S_OUT       = 5'd31;

   logic [4:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [2:0] k_ff, k_in;
   logic [1:0] passes_ff, passes_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      k_in      = k_ff;
      passes_in = passes_ff;
      cmd.op    = CMD_NOP;
      cmd.sub   = k_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = CMD_ACCEPT;
               op_in    = req_operation;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (op_ff)
               OP_SEED_START: state_in = S_SINIT;
               OP_SEED_BYTE:  state_in = S_SB_CHK;
               OP_SEED_FINISH: begin
                  passes_in = 2'd2;
                  state_in  = S_MX_BEGIN;
               end
               default: state_in = S_DR_CHK;
            endcase
         end
         S_SINIT: begin
            cmd.op   = CMD_SEED_INIT;
            state_in = S_IDLE;
         end
         // Seed byte: a full window is mixed before the byte goes in.
         S_SB_CHK: begin
            if (status.c_ge) begin
               passes_in = 2'd1;
               state_in  = S_MX_BEGIN;
            end else begin
               state_in = S_SB_RD;
            end
         end
         S_SB_RD: begin
            cmd.op   = CMD_SB_RD;
            state_in = S_SB_WR;
         end
         S_SB_WR: begin
            cmd.op   = CMD_SB_WR;
            state_in = S_IDLE;
         end
         // Mix pass: eight reads, eight hash lines, eight writes per group.
         S_MX_BEGIN: begin
            cmd.op   = CMD_MIX_BEGIN;
            k_in     = 3'd0;
            state_in = S_MX_RD;
         end
         S_MX_RD: begin
            cmd.op   = CMD_MIX_RD;
            state_in = S_MX_ACC;
         end
         S_MX_ACC: begin
            cmd.op   = CMD_MIX_ACC;
            k_in     = k_ff + 3'd1;
            state_in = (k_ff == 3'd7) ? S_MX_RND : S_MX_RD;
         end
         S_MX_RND: begin
            cmd.op   = CMD_MIX_ROUND;
            k_in     = k_ff + 3'd1;
            state_in = (k_ff == 3'd7) ? S_MX_WR : S_MX_RND;
         end
         S_MX_WR: begin
            cmd.op = CMD_MIX_WR;
            k_in   = k_ff + 3'd1;
            if (k_ff == 3'd7) begin
               state_in = status.grp_last ? S_MX_END : S_MX_NEXT;
            end
         end
         S_MX_NEXT: begin
            cmd.op   = CMD_MIX_NEXT;
            state_in = S_MX_RD;
         end
         S_MX_END: begin
            cmd.op    = CMD_MIX_END;
            passes_in = passes_ff - 2'd1;
            state_in  = (passes_ff == 2'd2) ? S_MX_BEGIN : S_CCLR;
         end
         S_CCLR: begin
            cmd.op   = CMD_C_CLEAR;
            state_in = (op_ff == OP_SEED_BYTE) ? S_SB_RD : S_IDLE;
         end
         // Draw: rejection limit first, unless the range is the full word.
         S_DR_CHK: begin
            state_in = status.n_zero ? S_RAW_CHK : S_LIM_START;
         end
         S_LIM_START: begin
            cmd.op   = CMD_MOD_LIM;
            state_in = S_LIM_STEP;
         end
         S_LIM_STEP: begin
            cmd.op = CMD_MOD_STEP;
            if (status.mod_last) begin
               state_in = S_LIM_END;
            end
         end
         S_LIM_END: begin
            cmd.op   = CMD_LIM_SAVE;
            state_in = S_RAW_CHK;
         end
         S_RAW_CHK: begin
            state_in = status.need_refill ? S_RF_BEGIN : S_RAW_RD;
         end
         // Refill: six steps per word over the single pool port.
         S_RF_BEGIN: begin
            cmd.op   = CMD_RF_BEGIN;
            state_in = S_RF_OTHER;
         end
         S_RF_OTHER: begin
            cmd.op   = CMD_RF_RD_OTHER;
            state_in = S_RF_A;
         end
         S_RF_A: begin
            cmd.op   = CMD_RF_A;
            state_in = S_RF_X;
         end
         S_RF_X: begin
            cmd.op   = CMD_RF_X;
            state_in = S_RF_Y;
         end
         S_RF_Y: begin
            cmd.op   = CMD_RF_Y;
            state_in = S_RF_RD_B;
         end
         S_RF_RD_B: begin
            cmd.op   = CMD_RF_RD_B;
            state_in = S_RF_B;
         end
         S_RF_B: begin
            cmd.op   = CMD_RF_B;
            state_in = status.idx_last ? S_RF_END : S_RF_OTHER;
         end
         S_RF_END: begin
            cmd.op   = CMD_RF_END;
            state_in = S_RAW_RD;
         end
         S_RAW_RD: begin
            cmd.op   = CMD_RAW_RD;
            state_in = S_RAW_EVAL;
         end
         S_RAW_EVAL: begin
            if (status.n_zero) begin
               state_in = S_OUT;
            end else if (status.x_lt_lim) begin
               state_in = S_RAW_CHK;
            end else begin
               state_in = S_X_START;
            end
         end
         S_X_START: begin
            cmd.op   = CMD_MOD_X;
            state_in = S_X_STEP;
         end
         S_X_STEP: begin
            cmd.op = CMD_MOD_STEP;
            if (status.mod_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            cmd.op   = CMD_OUT;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         op_ff     <= OP_SEED_START;
         k_ff      <= '0;
         passes_ff <= '0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         k_ff      <= k_in;
         passes_ff <= passes_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: rtl/isaac_random_generator_unit.sv
// Top level of the ISAAC random generator: controller plus datapath.
// Depends on isaac_pkg, isaac_ctl and isaac_dp.
//
// Usage: a transaction is accepted at a rising edge where start is high and
// busy is low; req_operation selects seed start, seed byte, seed finish or
// draw, req_seed_byte and req_bound carry the operands. Only a draw gives a
// result: rsp_value is valid for exactly one cycle while rsp_strobe is high,
// and the receiver cannot hold it off. busy stays high until the transaction
// is done, and one transaction is worked on at a time.
// Busy time: a seed byte adds one mix pass when the byte window is full;
// seed finish runs two mix passes. A draw works out the rejection limit,
// takes words until one is not below the limit and does the final modulo,
// the modulo work done by the one-bit-per-cycle modulo unit; a refill of
// the output buffer is added when it is empty, done over the single pool
// memory port. An all-ones bound skips the modulo.
// Reset loads the seed-start state at once (all pool entries read as zero).
module isaac_random_generator_unit #(
   parameter int WORDS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_seed_byte,
   input  logic [31:0] req_bound,
   output logic        rsp_strobe,
   output logic [31:0] rsp_value
);
   import isaac_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   isaac_ctl u_ctl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .busy          (busy),
      .status        (status),
      .cmd           (cmd)
   );

   isaac_dp #(.WORDS(WORDS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_seed_byte (req_seed_byte),
      .req_bound     (req_bound),
      .rsp_strobe    (rsp_strobe),
      .rsp_value     (rsp_value)
   );

endmodule

FILE: rtl/isaac_checker.sv
// Port-level checks of the ISAAC random generator, bound to the top level.
// Depends only on the top level's ports.
module isaac_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // An accepted transaction makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted transaction did not raise busy");

   // A result lasts one cycle and is never followed directly by another.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe longer than one cycle");

   // A result only follows a cycle of work.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("result without a transaction in work");

   // Reset leaves the block idle with no result.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe) else $error("block not idle after reset");

endmodule

bind isaac_random_generator_unit isaac_checker u_isaac_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
